@@ rtl/ptsf_pkg.sv @@
// Package with the constants and codes of the pan-tilt slew command framer.
`timescale 1ns / 1ps

package ptsf_pkg;

	// Fixed-point format of the wanted position: 8 integer bits over FRAC_BITS fraction bits.
	localparam int FRAC_BITS = 12;
	localparam int WP_W      = 8 + FRAC_BITS;
	// Speed times gain: 16-bit signed speed times at most 10, with room for negation.
	localparam int PROD_W    = 21;
	// Wanted position plus the scaled speed, signed.
	localparam int SUM_W     = ((WP_W + 1 > PROD_W) ? WP_W + 1 : PROD_W) + 1;
	localparam logic [WP_W:0] HALF = (WP_W + 1)'(1) << (FRAC_BITS - 1);

	// Input opcodes.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_SPEED  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_BODY_LIMITS = 2'd0;
	localparam logic [1:0] REG_EYE_LIMITS  = 2'd1;
	localparam logic [1:0] REG_SPEED_MODE  = 2'd2;

	// Frame bytes.
	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_CMD = 8'h41;
	localparam logic [7:0] BYTE_ETX = 8'h03;
	localparam logic [31:0] LIMITS_RESET = 32'hFF00FF00;

	// Byte positions within one frame.
	localparam logic [2:0] POS_STX  = 3'd0;
	localparam logic [2:0] POS_CMD  = 3'd1;
	localparam logic [2:0] POS_UNIT = 3'd2;
	localparam logic [2:0] POS_X    = 3'd3;
	localparam logic [2:0] POS_Y    = 3'd4;
	localparam logic [2:0] POS_ETX  = 3'd5;

endpackage

@@ rtl/pan_tilt_slew_command_framer.sv @@
// An accepted item is held in the input register until it retires; as it retires, its state
// update is made and its frames, if any, move into the output register, which offers the first
// byte in the cycle after the item retires.
// One item is taken per cycle while the output register is free; a tick with frames holds
// it until its six or twelve frame bytes are taken. Reset (arst_n low, asynchronous) clears all positions,
// speeds and sent positions, sets the limits to 0..255 on both axes and selects the slow gain.
`timescale 1ns / 1ps

module pan_tilt_slew_command_framer
	import ptsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input item channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic               unit_select,
	input  logic [7:0]         target_x,
	input  logic [7:0]         target_y,
	input  logic signed [15:0] speed_x,
	input  logic signed [15:0] speed_y,
	// Frame byte channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_byte,
	output logic               frame_end,
	output logic               last,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers.
	logic [31:0] body_limits_q;
	logic [31:0] eye_limits_q;
	logic        speed_mode_q;

	// Per-axis state, indexed by unit * 2 + axis.
	logic [WP_W-1:0]    wanted_q [4];
	logic [7:0]         sent_q   [4];
	logic signed [15:0] speed_q  [4];

	// Input register.
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic               unit_s1;
	logic [7:0]         tx_s1;
	logic [7:0]         ty_s1;
	logic signed [15:0] sx_s1;
	logic signed [15:0] sy_s1;

	// Output register and byte sequencer.
	logic        res_valid_q;
	logic [1:0]  res_frames_q;
	logic [7:0]  res_pos_q [4];
	logic [2:0]  cnt_q;
	logic        unit_q;

	// Tick arithmetic.
	logic [31:0]              lim;
	logic [7:0]               lo;
	logic [7:0]               hi;
	logic signed [PROD_W-1:0] p5;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  v;
	logic signed [SUM_W-1:0]  mn;
	logic signed [SUM_W-1:0]  mx;
	logic [WP_W:0]            rnd;
	logic [WP_W-1:0]          wp_next  [4];
	logic [7:0]               pos_next [4];
	logic [1:0]               frames;

	logic cfg_wr;
	logic in_acc;
	logic out_acc;
	logic is_tick;
	logic res_free;
	logic retire;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limits_q <= LIMITS_RESET;
			eye_limits_q  <= LIMITS_RESET;
			speed_mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BODY_LIMITS: body_limits_q <= pwdata;
				REG_EYE_LIMITS:  eye_limits_q  <= pwdata;
				REG_SPEED_MODE:  speed_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Configuration reads.
	always_comb begin
		case (paddr[3:2])
			REG_BODY_LIMITS: prdata = body_limits_q;
			REG_EYE_LIMITS:  prdata = eye_limits_q;
			REG_SPEED_MODE:  prdata = {31'd0, speed_mode_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Advance every axis by speed times gain (negated on the x axes), clamp and round.
	always_comb begin
		lim  = body_limits_q;
		lo   = '0;
		hi   = '0;
		p5   = '0;
		prod = '0;
		v    = '0;
		mn   = '0;
		mx   = '0;
		rnd  = '0;
		for (int i = 0; i < 4; i++) begin
			lim  = i[1] ? eye_limits_q : body_limits_q;
			lo   = i[0] ? lim[23:16] : lim[7:0];
			hi   = i[0] ? lim[31:24] : lim[15:8];
			p5   = (PROD_W'(speed_q[i]) <<< 2) + PROD_W'(speed_q[i]);
			prod = speed_mode_q ? (p5 <<< 1) : p5;
			if (!i[0]) begin
				prod = -prod;
			end
			v  = $signed(SUM_W'(wanted_q[i])) + SUM_W'(prod);
			mn = $signed(SUM_W'({lo, {FRAC_BITS{1'b0}}}));
			mx = $signed(SUM_W'({hi, {FRAC_BITS{1'b0}}}));
			if (v < mn) begin
				v = mn;
			end
			if (v > mx) begin
				v = mx;
			end
			wp_next[i]  = v[WP_W-1:0];
			rnd         = {1'b0, v[WP_W-1:0]} + HALF;
			pos_next[i] = rnd[FRAC_BITS +: 8];
		end
		frames[0] = (pos_next[0] != sent_q[0]) || (pos_next[1] != sent_q[1]);
		frames[1] = (pos_next[2] != sent_q[2]) || (pos_next[3] != sent_q[3]);
	end

	// Handshake and retire control.
	assign out_valid = res_valid_q;
	assign out_acc   = out_valid && out_ready;
	assign res_free  = !res_valid_q || (out_acc && last);
	assign is_tick   = (op_s1 == OP_TICK);
	assign retire    = valid_s1 && (!is_tick || (frames == 2'b00) || res_free);
	assign in_ready  = !valid_s1 || retire;
	assign in_acc    = in_valid && in_ready;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= opcode;
			unit_s1 <= unit_select;
			tx_s1   <= target_x;
			ty_s1   <= target_y;
			sx_s1   <= speed_x;
			sy_s1   <= speed_y;
		end
	end

	// Axis state update as an item retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				wanted_q[i] <= '0;
				sent_q[i]   <= '0;
				speed_q[i]  <= '0;
			end
		end else if (retire) begin
			for (int i = 0; i < 4; i++) begin
				case (op_s1)
					OP_TICK: begin
						wanted_q[i] <= wp_next[i];
						if (frames[i / 2]) begin
							sent_q[i] <= pos_next[i];
						end
					end
					OP_TARGET: begin
						if (i[1] == unit_s1) begin
							wanted_q[i] <= {(i[0] ? ty_s1 : tx_s1), {FRAC_BITS{1'b0}}};
						end
					end
					OP_SPEED: begin
						if (i[1] == unit_s1) begin
							speed_q[i] <= i[0] ? sy_s1 : sx_s1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Output register and byte sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			res_frames_q <= 2'b00;
			cnt_q        <= POS_STX;
			unit_q       <= 1'b0;
		end else if (retire && is_tick && (frames != 2'b00)) begin
			res_valid_q  <= 1'b1;
			res_frames_q <= frames;
			cnt_q        <= POS_STX;
			unit_q       <= !frames[0];
		end else if (out_acc) begin
			if (last) begin
				res_valid_q <= 1'b0;
			end else if (cnt_q == POS_ETX) begin
				cnt_q  <= POS_STX;
				unit_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Output register positions.
	always_ff @(posedge clk) begin
		if (retire && is_tick && (frames != 2'b00)) begin
			for (int i = 0; i < 4; i++) begin
				res_pos_q[i] <= pos_next[i];
			end
		end
	end

	// Byte selection for the current beat.
	always_comb begin
		case (cnt_q)
			POS_STX:  frame_byte = BYTE_STX;
			POS_CMD:  frame_byte = BYTE_CMD;
			POS_UNIT: frame_byte = {7'd0, unit_q};
			POS_X:    frame_byte = res_pos_q[{unit_q, 1'b0}];
			POS_Y:    frame_byte = res_pos_q[{unit_q, 1'b1}];
			POS_ETX:  frame_byte = BYTE_ETX;
			default:  frame_byte = BYTE_ETX;
		endcase
	end

	assign frame_end = (cnt_q == POS_ETX);
	assign last      = frame_end && (unit_q || !res_frames_q[1]);

`ifndef SYNTH
	// A held output register always has at least one frame to send.
	a_frames_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_frames_q != 2'b00))
		else $error("output register valid with no frame");

	// The final beat of a tick always closes a frame.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> frame_end)
		else $error("last beat is not a frame end");

	// A tick's bytes are not cut short after a non-final beat.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last) |=> out_valid)
		else $error("output dropped before the final beat");

	// A stalled input item holds its opcode.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !retire) |=> (valid_s1 && $stable(op_s1)))
		else $error("stalled input item lost");

	// The eye frame is only sent from a tick that has it.
	a_eye_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unit_q) |-> res_frames_q[1])
		else $error("eye frame sent without a request");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the pan-tilt slew command framer.
`timescale 1ns / 1ps

module testbench;
	import ptsf_pkg::*;

	// Codes the package does not name.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_AT       = 120;
	localparam int HOLD_CYCLES   = 150;
	localparam int STALL_LIMIT   = 1000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 53;

	typedef struct packed {
		logic [7:0] data;
		logic       fend;
		logic       lst;
	} frame_beat_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} check_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  op;
		logic        unit;
		logic [7:0]  tx;
		logic [7:0]  ty;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
	} stim_row_t;

	typedef struct packed {
		check_t     kind;
		logic       fu;
		logic [7:0] fx;
		logic [7:0] fy;
	} item_check_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic               unit_select;
	logic [7:0]         target_x;
	logic [7:0]         target_y;
	logic signed [15:0] speed_x;
	logic signed [15:0] speed_y;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         frame_byte;
	logic               frame_end;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Mirror of the block state and its registers.
	logic [WP_W-1:0]    want_pos [4];
	logic [7:0]         sent_pos [4];
	logic signed [15:0] speed_mirror [4];
	logic [31:0]        limit_mirror [2];
	logic               fast_mirror;
	frame_beat_t        tick_beats [12];

	frame_beat_t        due_bytes [$];
	stim_row_t          directed_rows [$];
	item_check_t        item_checks [$];
	int                 item_count;
	int                 beats_taken;
	int                 mismatches;
	int                 send_calm;

	pan_tilt_slew_command_framer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.unit_select (unit_select),
		.target_x    (target_x),
		.target_y    (target_y),
		.speed_x     (speed_x),
		.speed_y     (speed_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.frame_end   (frame_end),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Free-running clock with a 4 ns period.
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t ns: %s, got %0h, expected %0h", $time, what, got, want);
	endtask

	// Wait before the next beat; now and then a calm stretch with no waits at all.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = 24;
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// One byte of the frame STX, 'A', unit, x, y, ETX.
	function automatic frame_beat_t frame_beat(input logic u, input logic [7:0] x,
			input logic [7:0] y, input int k, input logic fin);
		frame_beat_t b;
		b.fend = (k == POS_ETX);
		b.lst  = fin;
		case (3'(k))
			POS_STX: b.data = BYTE_STX;
			POS_CMD: b.data = BYTE_CMD;
			POS_UNIT: b.data = {7'd0, u};
			POS_X: b.data = x;
			POS_Y: b.data = y;
			default: b.data = BYTE_ETX;
		endcase
		return b;
	endfunction

	// Move one axis by speed times gain, clamp, and round half up to a hardware position.
	function automatic logic [7:0] slew_axis(input int idx, input longint gain,
			input logic [7:0] lo, input logic [7:0] hi);
		longint pos, floor_pos, ceil_pos;
		pos = longint'(want_pos[idx]) + longint'(speed_mirror[idx]) * gain;
		floor_pos = longint'(lo) << FRAC_BITS;
		ceil_pos = longint'(hi) << FRAC_BITS;
		if (pos < floor_pos) begin
			pos = floor_pos;
		end
		if (pos > ceil_pos) begin
			pos = ceil_pos;
		end
		want_pos[idx] = WP_W'(pos);
		return 8'((pos + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
	endfunction

	// Apply one command to the mirror; returns the number of frame beats in tick_beats.
	function automatic int apply_command(input logic [1:0] op, input logic u,
			input logic [7:0] tx, input logic [7:0] ty, input logic [15:0] sx,
			input logic [15:0] sy);
		int n;
		longint gain;
		logic [31:0] lim;
		logic [7:0] px, py;
		n = 0;
		case (op)
			OP_TARGET: begin
				want_pos[u * 2] = WP_W'(tx) << FRAC_BITS;
				want_pos[u * 2 + 1] = WP_W'(ty) << FRAC_BITS;
			end
			OP_SPEED: begin
				speed_mirror[u * 2] = sx;
				speed_mirror[u * 2 + 1] = sy;
			end
			OP_TICK: begin
				gain = fast_mirror ? 10 : 5;
				// Body first, then eye; a frame only when the rounded position moved.
				for (int v = 0; v < 2; v++) begin
					lim = limit_mirror[v];
					px = slew_axis(v * 2, -gain, lim[7:0], lim[15:8]);
					py = slew_axis(v * 2 + 1, gain, lim[23:16], lim[31:24]);
					if (px != sent_pos[v * 2] || py != sent_pos[v * 2 + 1]) begin
						for (int k = 0; k < 6; k++) begin
							tick_beats[n] = frame_beat(1'(v), px, py, k, 1'b0);
							n++;
						end
						sent_pos[v * 2] = px;
						sent_pos[v * 2 + 1] = py;
					end
				end
				if (n > 0) begin
					tick_beats[n - 1].lst = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	task automatic add_item(input logic [1:0] op, input logic u, input logic [7:0] tx,
			input logic [7:0] ty, input logic [15:0] sx, input logic [15:0] sy,
			input check_t chk, input logic fu, input logic [7:0] fx, input logic [7:0] fy);
		stim_row_t r;
		item_check_t c;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = op;
		r.unit = u;
		r.tx = tx;
		r.ty = ty;
		r.sx = sx;
		r.sy = sy;
		directed_rows.push_back(r);
		c.kind = chk;
		c.fu = fu;
		c.fx = fx;
		c.fy = fy;
		item_checks.push_back(c);
	endtask

	task automatic add_reg(input logic [1:0] idx, input logic [31:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		directed_rows.push_back(r);
	endtask

	// Offer one input beat and hold it until it is taken.
	task automatic send_item(input logic [1:0] op, input logic u, input logic [7:0] tx,
			input logic [7:0] ty, input logic [15:0] sx, input logic [15:0] sy);
		int n;
		n = draw_wait(send_calm);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		unit_select <= u;
		target_x <= tx;
		target_y <= ty;
		speed_x <= sx;
		speed_y <= sy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Register write once the block has gone idle: setup phase, then access phase.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		while (due_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_BODY_LIMITS: limit_mirror[0] = val;
			REG_EYE_LIMITS: limit_mirror[1] = val;
			REG_SPEED_MODE: fast_mirror = val[0];
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Limits for one unit: reset value, all zero, all ones, raw random or ordered ranges.
	function automatic logic [31:0] pick_limits();
		logic [7:0] a, b, c, d;
		a = 8'($urandom);
		b = 8'($urandom);
		c = 8'($urandom);
		d = 8'($urandom);
		case ($urandom_range(0, 5))
			0: return LIMITS_RESET;
			1: return 32'h0000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'($urandom);
			default: begin
				return {(c > d) ? c : d, (c > d) ? d : c, (a > b) ? a : b, (a > b) ? b : a};
			end
		endcase
	endfunction

	// Scoreboard: check each output beat, then predict for each accepted input beat.
	always @(posedge clk) begin : scoreboard
		frame_beat_t want;
		int n;
		item_check_t chk;
		if (out_valid && out_ready) begin
			if (due_bytes.size() == 0) begin
				report_mismatch("frame byte with nothing expected", 32'(frame_byte), 0);
			end else begin
				want = due_bytes.pop_front();
				if (frame_byte !== want.data) begin
					report_mismatch("frame_byte", 32'(frame_byte), 32'(want.data));
				end
				if (frame_end !== want.fend) begin
					report_mismatch("frame_end", 32'(frame_end), 32'(want.fend));
				end
				if (last !== want.lst) begin
					report_mismatch("last", 32'(last), 32'(want.lst));
				end
			end
		end
		if (in_valid && in_ready) begin
			n = apply_command(opcode, unit_select, target_x, target_y, speed_x, speed_y);
			if (item_count < item_checks.size() && item_checks[item_count].kind != CHK_MODEL) begin
				chk = item_checks[item_count];
				if (chk.kind == CHK_FRAME) begin
					for (int k = 0; k < 6; k++) begin
						due_bytes.push_back(frame_beat(chk.fu, chk.fx, chk.fy, k, k == POS_ETX));
					end
				end
			end else begin
				for (int k = 0; k < n; k++) begin
					due_bytes.push_back(tick_beats[k]);
				end
			end
			item_count++;
		end
	end

	// Frame sink with random stalls and one long hold-off that backs the block up.
	initial begin : frame_sink
		int calm, n;
		calm = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			n = (beats_taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(calm);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			beats_taken++;
			@(negedge clk);
		end
	end

	// Watchdog: too long without any beat or register access ends the run.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		wait (arst_n === 1'b1);
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	// Stimulus: directed table first, then random phases with fresh register settings.
	initial begin : stimulus
		int counted, r;
		logic [1:0] op;
		logic [15:0] sx, sy;
		stim_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		unit_select = 1'b0;
		target_x = 8'd0;
		target_y = 8'd0;
		speed_x = 16'sd0;
		speed_y = 16'sd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		item_count = 0;
		beats_taken = 0;
		mismatches = 0;
		send_calm = 0;
		for (int i = 0; i < 4; i++) begin
			want_pos[i] = '0;
			sent_pos[i] = '0;
			speed_mirror[i] = '0;
		end
		limit_mirror[0] = LIMITS_RESET;
		limit_mirror[1] = LIMITS_RESET;
		fast_mirror = 1'b0;

		// Reset state, full-scale target, unknown opcode, extreme speeds.
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_TARGET, 1'b0, 8'hFF, 8'hFF, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_FRAME, 0, 8'hFF, 8'hFF);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_UNKNOWN, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, CHK_NONE, 0, 0, 0);
		add_item(OP_TARGET, 1'b1, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, CHK_NONE, 0, 0, 0);
		add_item(OP_SPEED, 1'b0, 8'hFF, 8'hFF, 16'h8000, 16'h7FFF, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_SPEED, 1'b0, 8'h00, 8'h00, 16'h7FFF, 16'h8000, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		// Fast gain on both units.
		add_reg(REG_SPEED_MODE, 32'd1);
		add_item(OP_TICK, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		add_item(OP_SPEED, 1'b1, 8'h00, 8'h00, 16'h8000, 16'h7FFF, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		// Crossed body limits: the clamp lands on the maximum.
		add_reg(REG_BODY_LIMITS, 32'h00FF_64C8);
		add_item(OP_TARGET, 1'b0, 8'd50, 8'd50, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		add_reg(REG_EYE_LIMITS, 32'h8080_8080);
		add_reg(REG_SPEED_MODE, 32'd0);
		add_reg(REG_UNUSED, 32'hFFFF_FFFF);
		add_reg(REG_BODY_LIMITS, LIMITS_RESET);
		// Two and a half steps per axis: rounding half up from 12.5.
		add_item(OP_TARGET, 1'b0, 8'd10, 8'd10, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_SPEED, 1'b0, 8'h00, 8'h00, 16'hF800, 16'h0800, CHK_NONE, 0, 0, 0);
		add_item(OP_SPEED, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		// Eye limits pinned to the top, then to the bottom.
		add_reg(REG_EYE_LIMITS, 32'hFFFF_FFFF);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		add_reg(REG_EYE_LIMITS, 32'h0000_0000);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);
		add_reg(REG_SPEED_MODE, 32'hFFFF_FFFE);
		add_reg(REG_EYE_LIMITS, LIMITS_RESET);
		add_item(OP_TARGET, 1'b1, 8'hFF, 8'h00, 16'h0000, 16'h0000, CHK_NONE, 0, 0, 0);
		add_item(OP_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000, CHK_MODEL, 0, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.op, row.unit, row.tx, row.ty, row.sx, row.sy);
			end
		end

		// Random phases; mostly ticks and speed changes, some jumps and stray opcodes.
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_BODY_LIMITS, pick_limits());
			write_reg(REG_EYE_LIMITS, pick_limits());
			write_reg(REG_SPEED_MODE, 32'($urandom));
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_UNUSED, 32'($urandom));
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				op = (r < 8) ? OP_UNKNOWN : (r < 48) ? OP_TICK : (r < 76) ? OP_SPEED : OP_TARGET;
				sx = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 1200)) - 600);
				sy = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 1200)) - 600);
				send_item(op, 1'($urandom), 8'($urandom), 8'($urandom), sx, sy);
				if (op != OP_UNKNOWN) begin
					counted++;
				end
			end
		end
		in_valid <= 1'b0;

		// Drain: every expected beat in, then a few quiet cycles for strays.
		while (due_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/ptsf_pkg.sv
rtl/pan_tilt_slew_command_framer.sv
dv/testbench.sv
